[hdl/mavg_pkg.sv]
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared constants, register indexes and control types of the boxcar
// moving-average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

    // widths fixed by the item and register formats
    localparam int SAMPLE_W    = 16;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    // default ring capacity
    localparam int DEFAULT_MAX_WINDOW = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_PASS_MODE = 1'd1;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RESET = 7'd8;

    // item commands
    localparam logic CMD_FLUSH = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic flush;
        logic load_item;
        logic fetch;
        logic update;
        logic mid_read;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic result_due;
        logic div_done;
    } dp_status_t;

endpackage

[hdl/mavg_if.sv]
// ----------------------------------------------------------------------------
// mavg_if
// Valid/ready channels of the moving-average filter: sample items in,
// filtered items out.
// ----------------------------------------------------------------------------
interface mavg_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [mavg_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output command, output sample_in, input ready);
    modport sink   (input valid, input command, input sample_in, output ready);
endinterface

interface mavg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mavg_pkg::SAMPLE_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

[hdl/mavg_div.sv]
// ----------------------------------------------------------------------------
// mavg_div
// Restoring unsigned divider, one quotient bit per cycle. Used for the
// magnitude of the running sum over the window length.
// ----------------------------------------------------------------------------
module mavg_div #(
    parameter int N_W = 22,
    parameter int D_W = 7
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient,
    output logic           busy
);

    localparam int CW = $clog2(N_W + 1);

    logic [D_W-1:0] rem_reg;
    logic [N_W-1:0] quo_reg;
    logic [CW-1:0]  count_reg;
    logic           busy_reg;

    logic [D_W:0]   trial;
    logic           ge;
    logic [D_W:0]   rem_new;

    // one restoring step
    always_comb
    begin
        trial   = {rem_reg, quo_reg[N_W-1]};
        ge      = (trial >= {1'b0, divisor});
        rem_new = ge ? (trial - {1'b0, divisor}) : trial;
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CW'(N_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

[hdl/mavg_datapath.sv]
// ----------------------------------------------------------------------------
// mavg_datapath
// Sample ring, running sum, fill and position state, configuration
// registers, divider and output register of the moving-average filter.
// ----------------------------------------------------------------------------
module mavg_datapath #(
    parameter int MAX_WINDOW = mavg_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [mavg_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [mavg_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0]    sample_in,
    output logic signed [mavg_pkg::SAMPLE_W-1:0]    filtered,
    input  mavg_pkg::ctrl_cmd_t                     cmd,
    output mavg_pkg::dp_status_t                    status
);

    localparam int SW      = mavg_pkg::SAMPLE_W;
    localparam int EFF_MAX = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
    localparam int IW      = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam int WW      = $clog2(EFF_MAX + 1);
    localparam int SUM_W   = SW + $clog2(EFF_MAX);

    // configuration registers
    logic [mavg_pkg::CFG_DATA_W-1:0] window_length_reg;
    logic                            high_pass_reg;

    // window state
    logic signed [SUM_W-1:0] sum_reg;
    logic [IW-1:0]           oldest_reg;
    logic [WW-1:0]           fill_reg;
    logic                    full_reg;

    // item and memory data
    logic signed [SW-1:0]    sample_reg;
    logic signed [SW-1:0]    rd_data_reg;
    logic signed [SW-1:0]    filtered_reg;
    logic signed [SW-1:0]    ring [EFF_MAX];

    logic                    clear_fill;
    logic [WW-1:0]           win;
    logic [WW-1:0]           fill_inc;
    logic [WW-1:0]           oldest_inc;
    logic [WW-1:0]           half;
    logic [WW:0]             mid_sum;
    logic [WW:0]             mid_pos;
    logic [IW-1:0]           rd_addr;
    logic [IW-1:0]           wr_addr;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        sum_mag;
    logic [SUM_W-1:0]        quotient;
    logic                    div_busy;
    logic [SUM_W-1:0]        avg;
    logic signed [SW-1:0]    result;

    // configuration writes; a new window length restarts the fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= mavg_pkg::WINDOW_LENGTH_RESET;
            high_pass_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == mavg_pkg::REG_WINDOW_LENGTH)
            begin
                window_length_reg <= cfg_data;
            end
            if (cfg_index == mavg_pkg::REG_HIGH_PASS_MODE)
            begin
                high_pass_reg <= cfg_data[0];
            end
        end
    end

    assign clear_fill = cmd.flush ||
                        (cfg_write && (cfg_index == mavg_pkg::REG_WINDOW_LENGTH));

    // effective window: zero counts as one, clipped to the ring size
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            win = WW'(1);
        end
        else if (window_length_reg > 7'(EFF_MAX))
        begin
            win = WW'(EFF_MAX);
        end
        else
        begin
            win = WW'(window_length_reg);
        end
    end

    // positions: fill step, oldest advance, middle sample
    always_comb
    begin
        fill_inc   = fill_reg + WW'(1);
        oldest_inc = WW'(oldest_reg) + WW'(1);
        half       = (win - WW'(1)) >> 1;
        mid_sum    = (WW+1)'(oldest_reg) + (WW+1)'(half);
        mid_pos    = (mid_sum >= {1'b0, win}) ? (mid_sum - {1'b0, win}) : mid_sum;
        rd_addr    = cmd.mid_read ? mid_pos[IW-1:0] : oldest_reg;
        wr_addr    = full_reg ? oldest_reg : fill_reg[IW-1:0];
    end

    assign status.result_due = full_reg || (fill_inc == win);

    // new sum: add the sample, drop the oldest once the window is full
    always_comb
    begin
        sum_next = sum_reg + SUM_W'(sample_reg);
        if (full_reg)
        begin
            sum_next = sum_next - SUM_W'(rd_data_reg);
        end
    end

    // window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            oldest_reg <= '0;
            fill_reg   <= '0;
            full_reg   <= 1'b0;
        end
        else if (clear_fill)
        begin
            sum_reg    <= '0;
            oldest_reg <= '0;
            fill_reg   <= '0;
            full_reg   <= 1'b0;
        end
        else if (cmd.update)
        begin
            sum_reg <= sum_next;
            if (full_reg)
            begin
                oldest_reg <= (oldest_inc == win) ? '0 : oldest_inc[IW-1:0];
            end
            else
            begin
                fill_reg <= fill_inc;
                if (fill_inc == win)
                begin
                    full_reg   <= 1'b1;
                    oldest_reg <= '0;
                end
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sample_reg <= sample_in;
        end
    end

    // sample ring, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ring[wr_addr] <= sample_reg;
        end
        if (cmd.fetch || cmd.mid_read)
        begin
            rd_data_reg <= ring[rd_addr];
        end
    end

    // sum magnitude into the divider
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    mavg_div #(
        .N_W (SUM_W),
        .D_W (WW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_mag),
        .divisor  (win),
        .quotient (quotient),
        .busy     (div_busy)
    );

    assign status.div_done = !div_busy;

    // average with sign restored, then mode select
    always_comb
    begin
        avg = sum_reg[SUM_W-1] ? (SUM_W'(0) - quotient) : quotient;
        if (high_pass_reg)
        begin
            result = rd_data_reg - signed'(avg[SW-1:0]);
        end
        else
        begin
            result = signed'(avg[SW-1:0]);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            filtered_reg <= result;
        end
    end

    assign filtered = filtered_reg;

endmodule

[hdl/mavg_ctrl.sv]
// ----------------------------------------------------------------------------
// mavg_ctrl
// Sequencer of the moving-average filter: takes an item, steps the ring
// and sum update, runs the divider and hands the result to the output.
// ----------------------------------------------------------------------------
module mavg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_command,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mavg_pkg::dp_status_t status,
    output mavg_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_UPDATE = 6'b000100,
        S_MID    = 6'b001000,
        S_DIV    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == mavg_pkg::CMD_FLUSH)
                    begin
                        cmd.flush = 1'b1;
                    end
                    else
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.result_due ? S_MID : S_IDLE;
            end
            S_MID:
            begin
                cmd.mid_read  = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hdl/moving_average_lowpass_highpass_top.sv]
// ----------------------------------------------------------------------------
// moving_average_lowpass_highpass_top
// Boxcar moving-average filter with low-pass and high-pass output modes.
//
//   channel    dir  payload                      accepted when
//   sample_ch  in   command, sample_in           valid && ready
//   filter_ch  out  filtered                     valid && ready
//   cfg port   in   cfg_index, cfg_data          cfg_write
//
// A push that gives a result runs the serial divider, one quotient bit per
// cycle, before the next item is accepted. A push while the window fills
// skips the divider; a flush is taken without leaving the idle state.
// The ring is one memory with one read and one write port; no clearing pass.
// Reset clears configuration and window state but not the ring contents.
// A waiting result sits in the output register while the next item is taken;
// a new result waits for it to leave.
// ----------------------------------------------------------------------------
module moving_average_lowpass_highpass_top #(
    parameter int MAX_WINDOW = mavg_pkg::DEFAULT_MAX_WINDOW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mavg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mavg_pkg::CFG_DATA_W-1:0]  cfg_data,
    mavg_in_if.sink                          sample_ch,
    mavg_out_if.source                       filter_ch
);

    mavg_pkg::ctrl_cmd_t  cmd;
    mavg_pkg::dp_status_t status;

    // sequencer
    mavg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_ch.valid),
        .in_command (sample_ch.command),
        .in_ready   (sample_ch.ready),
        .out_valid  (filter_ch.valid),
        .out_ready  (filter_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // ring, sum, divider and output register
    mavg_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_in (sample_ch.sample_in),
        .filtered  (filter_ch.filtered),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[verif/tb_moving_average_lowpass_highpass_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_moving_average_lowpass_highpass_top
// Self-checking bench for the boxcar moving-average filter. A directed run
// covers full-scale samples, flushes, window length zero, a length write in
// the middle of a fill and the middle sample of an even window. Random phases
// follow, each with its own window and mode, some above the ring size.
// Every accepted sample item is run through a local filter model. Every
// filtered item is checked against the oldest prediction. Sender bursts and
// receiver stalls are random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_moving_average_lowpass_highpass_top;
    import mavg_pkg::*;

    localparam int  MAX_WINDOW    = DEFAULT_MAX_WINDOW;
    localparam logic CMD_PUSH     = 1'b0;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  RANDOM_PHASES = 14;
    localparam int  HOLDOFF_START = 430;
    localparam int  HOLDOFF_LEN   = 600;
    // run limit well above the slowest run, with its long gaps and stalls
    localparam int  CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic                        command;
        logic signed [SAMPLE_W-1:0] sample;
    } sample_item_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mavg_in_if  sample_if ();
    mavg_out_if filter_if ();

    moving_average_lowpass_highpass_top #(
        .MAX_WINDOW (MAX_WINDOW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_if),
        .filter_ch (filter_if)
    );

    // filter model state and its register copies
    logic signed [SAMPLE_W-1:0] window_ring [MAX_WINDOW];
    int                         window_sum   = 0;
    int                         oldest_pos   = 0;
    int                         fill_level   = 0;
    bit                         window_ready = 1'b0;
    logic [CFG_DATA_W-1:0]      window_reg   = WINDOW_LENGTH_RESET;
    bit                         high_pass    = 1'b0;

    logic [SAMPLE_W-1:0] filtered_expect [$];
    sample_item_t        pending_items [$];
    sample_item_t        drive_item;

    int  queued_count   = 0;
    int  accepted_count = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  burst_left     = 0;
    int  gap_left       = 0;
    int  holdoff_left   = 0;
    bit  holdoff_done   = 1'b0;
    bit  item_taken     = 1'b0;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // known input levels from time zero
    initial
    begin
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = REG_WINDOW_LENGTH;
        cfg_data          = '0;
        sample_if.valid   = 1'b0;
        sample_if.command = CMD_PUSH;
        sample_if.sample_in = '0;
        filter_if.ready   = 1'b0;
    end

    // window length as the block uses it
    function automatic int active_window();
        int w;
        w = window_reg;
        if (w == 0)
            w = 1;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        return w;
    endfunction

    function automatic void clear_window();
        window_sum   = 0;
        oldest_pos   = 0;
        fill_level   = 0;
        window_ready = 1'b0;
    endfunction

    // average, or middle sample minus average, wrapped to the sample width
    function automatic logic [SAMPLE_W-1:0] filter_value(input int w);
        int avg;
        int y;
        avg = window_sum / w;
        if (high_pass)
            y = int'(window_ring[(oldest_pos + (w - 1) / 2) % w]) - avg;
        else
            y = avg;
        return y[SAMPLE_W-1:0];
    endfunction

    // one accepted item through the filter; queues the result it gives
    function automatic void filter_step(input logic cmd,
                                        input logic signed [SAMPLE_W-1:0] x);
        int w;
        w = active_window();
        if (cmd == CMD_FLUSH)
        begin
            clear_window();
            return;
        end
        if (!window_ready)
        begin
            if (fill_level >= w)
                fill_level = 0;
            window_ring[fill_level] = x;
            window_sum = window_sum + int'(x);
            fill_level++;
            if (fill_level < w)
                return;
            window_ready = 1'b1;
            oldest_pos   = 0;
        end
        else
        begin
            if (oldest_pos >= w)
                oldest_pos = 0;
            window_sum = window_sum + int'(x) - int'(window_ring[oldest_pos]);
            window_ring[oldest_pos] = x;
            oldest_pos = (oldest_pos + 1) % w;
        end
        filtered_expect.push_back(filter_value(w));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            3: return ($urandom_range(0, 1) == 0) ? 16'sh0000 : 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic cmd, input logic signed [SAMPLE_W-1:0] x);
        sample_item_t it;
        it.command = cmd;
        it.sample  = x;
        pending_items.push_back(it);
        queued_count++;
    endtask

    // all items taken, all results seen, then room for a push still in work
    task automatic wait_idle();
        while (accepted_count != queued_count || filtered_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write while the block is idle; model copy follows at once
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_WINDOW_LENGTH)
        begin
            window_reg = data;
            clear_window();
        end
        else if (idx == REG_HIGH_PASS_MODE)
            high_pass = data[0];
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // stimulus: directed run, then random phases
    initial
    begin
        int p;
        int n;
        int flush_pct;
        int win;
        bit hp;
        bit hp_only;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: full-scale windows, flush, partial fill
        repeat (8) queue_item(CMD_PUSH, 16'sh7FFF);
        repeat (2) queue_item(CMD_PUSH, 16'sh8000);
        queue_item(CMD_FLUSH, 16'sh1234);
        queue_item(CMD_PUSH, 16'sd100);
        queue_item(CMD_PUSH, -16'sd100);
        wait_idle();

        // length write drops the partial fill; window of one in high-pass
        write_register(REG_WINDOW_LENGTH, 7'd1);
        write_register(REG_HIGH_PASS_MODE, 7'd1);
        queue_item(CMD_PUSH, 16'sh8000);
        queue_item(CMD_PUSH, 16'sh7FFF);
        wait_idle();

        // window length zero acts as one
        write_register(REG_WINDOW_LENGTH, 7'd0);
        write_register(REG_HIGH_PASS_MODE, 7'd0);
        queue_item(CMD_PUSH, 16'sd5);
        wait_idle();

        // even window: middle is the older of the two centre samples
        write_register(REG_WINDOW_LENGTH, 7'd2);
        write_register(REG_HIGH_PASS_MODE, 7'd1);
        queue_item(CMD_PUSH, 16'sh7FFF);
        queue_item(CMD_PUSH, 16'sh8000);
        queue_item(CMD_PUSH, 16'sh0000);
        wait_idle();

        // random phases, each under its own settings
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            hp_only = 1'b0;
            case (p)
                0: begin win = 1;   hp = 1'b0; end
                1: begin win = 64;  hp = 1'b1; end
                2: begin win = 0;   hp = 1'b1; end
                3: begin win = 127; hp = 1'b0; end
                4: begin win = 65;  hp = 1'b1; end
                5: begin win = 3;   hp = 1'b1; end
                6: begin win = 2;   hp = 1'b0; end
                default:
                begin
                    win = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(1, 16);
                    hp = $urandom_range(0, 1);
                    hp_only = ($urandom_range(0, 2) == 0);
                end
            endcase
            if (!hp_only)
                write_register(REG_WINDOW_LENGTH, 7'(win));
            // upper data bits are don't-care for the mode register
            write_register(REG_HIGH_PASS_MODE, {6'($urandom), hp});

            if (p % 5 == 4)
                flush_pct = 12;
            else if (active_window() >= 32)
                flush_pct = 1;
            else
                flush_pct = 3;
            n = $urandom_range(95, 120);
            repeat (n)
                queue_item(($urandom_range(0, 99) < flush_pct) ? CMD_FLUSH : CMD_PUSH,
                           pick_sample());
            wait_idle();
        end

        if (mismatch_count == 0 && filtered_expect.size() == 0)
            $display("moving_average_lowpass_highpass_top test passed");
        else
            $display("moving_average_lowpass_highpass_top test failed");
        $finish;
    end

    // sample driver: bursts of items with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_if.valid <= 1'b0;
        else if (!sample_if.valid || item_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                sample_if.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                drive_item = pending_items.pop_front();
                sample_if.command   <= drive_item.command;
                sample_if.sample_in <= drive_item.sample;
                sample_if.valid     <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            else
                sample_if.valid <= 1'b0;
        end
    end

    // receiver stalls; one long hold-off while samples are on offer
    always @(negedge clk)
    begin
        if (!rst_n)
            filter_if.ready <= 1'b0;
        else if (holdoff_left > 0)
        begin
            holdoff_left--;
            filter_if.ready <= 1'b0;
        end
        else if (!holdoff_done && accepted_count >= HOLDOFF_START && sample_if.valid)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_LEN;
            filter_if.ready <= 1'b0;
        end
        else
        begin
            case ((cycle_count / 256) % 4)
                0: filter_if.ready <= 1'b1;
                1: filter_if.ready <= ($urandom_range(0, 1) == 0);
                2: filter_if.ready <= ((cycle_count % 64) >= 40);
                default: filter_if.ready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // monitor: check filtered items, then predict from accepted samples
    always @(posedge clk)
    begin
        item_taken <= rst_n && sample_if.valid && sample_if.ready;
        if (rst_n)
        begin
            if (filter_if.valid && filter_if.ready)
            begin
                if (filtered_expect.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected filtered item %0d", filter_if.filtered);
                end
                else if (filter_if.filtered !== filtered_expect[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("filtered mismatch: expected %0d got %0d",
                                 $signed(filtered_expect[0]), filter_if.filtered);
                    void'(filtered_expect.pop_front());
                end
                else
                    void'(filtered_expect.pop_front());
            end
            if (sample_if.valid && sample_if.ready)
            begin
                accepted_count++;
                filter_step(sample_if.command, sample_if.sample_in);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("moving_average_lowpass_highpass_top test failed");
            $finish;
        end
    end

endmodule

[sim.f]
hdl/mavg_pkg.sv
hdl/mavg_if.sv
hdl/mavg_div.sv
hdl/mavg_datapath.sv
hdl/mavg_ctrl.sv
hdl/moving_average_lowpass_highpass_top.sv
verif/tb_moving_average_lowpass_highpass_top.sv
